>>> hw/rtl/stgl_pkg.sv
// shared types and constants for the salience top-k gate learner
// no dependencies; imported by every module of the block
package stgl_pkg;

	localparam int MAX_CH     = 8;
	localparam int VAL_W      = 16;
	localparam int SAL_W      = 16;
	localparam int LR_W       = 17;
	localparam int KEEP_W     = 4;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam int PROD_W     = 31;
	localparam int TGT_W      = 20;

	localparam int CHANNELS_DEFAULT = 8;

	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 1'd1;

	localparam logic [SAL_W-1:0]  SAL_ONE    = 16'd8192;
	localparam logic [SAL_W-1:0]  SAL_MIN    = 16'd1638;
	localparam logic [SAL_W-1:0]  SAL_MAX    = 16'd32768;
	localparam logic [LR_W-1:0]   LR_MAX     = 17'd65536;
	localparam logic [LR_W-1:0]   LR_RESET   = 17'd6554;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_ATTEND
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} lane_ctrl_t;

endpackage

>>> hw/rtl/stgl_item_if.sv
// item channel interface: valid/ready handshake with command, reward and values
// depends on stgl_pkg for field widths
interface stgl_item_if
	import stgl_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic signed [VAL_W-1:0] reward;
	logic signed [VAL_W-1:0] value_0;
	logic signed [VAL_W-1:0] value_1;
	logic signed [VAL_W-1:0] value_2;
	logic signed [VAL_W-1:0] value_3;
	logic signed [VAL_W-1:0] value_4;
	logic signed [VAL_W-1:0] value_5;
	logic signed [VAL_W-1:0] value_6;
	logic signed [VAL_W-1:0] value_7;

	modport source (output valid, command, reward, value_0, value_1, value_2, value_3,
		value_4, value_5, value_6, value_7, input ready);
	modport sink (input valid, command, reward, value_0, value_1, value_2, value_3,
		value_4, value_5, value_6, value_7, output ready);
endinterface

>>> hw/rtl/stgl_result_if.sv
// result channel interface: valid/ready handshake with gated vector and counts
// depends on stgl_pkg for field widths
interface stgl_result_if
	import stgl_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] gated_0;
	logic signed [VAL_W-1:0] gated_1;
	logic signed [VAL_W-1:0] gated_2;
	logic signed [VAL_W-1:0] gated_3;
	logic signed [VAL_W-1:0] gated_4;
	logic signed [VAL_W-1:0] gated_5;
	logic signed [VAL_W-1:0] gated_6;
	logic signed [VAL_W-1:0] gated_7;
	logic [CNT_W-1:0]        attend_total;
	logic [CNT_W-1:0]        update_total;

	modport source (output valid, gated_0, gated_1, gated_2, gated_3, gated_4, gated_5,
		gated_6, gated_7, attend_total, update_total, input ready);
	modport sink (input valid, gated_0, gated_1, gated_2, gated_3, gated_4, gated_5,
		gated_6, gated_7, attend_total, update_total, output ready);
endinterface

>>> hw/rtl/stgl_lane.sv
// one channel lane: salience register, rank against all lanes, gating and update step
// depends on stgl_pkg
module stgl_lane
	import stgl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEFAULT,
	parameter int LANE     = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctrl_t              ctrl,
	input  logic signed [VAL_W-1:0] reward,
	input  logic signed [VAL_W-1:0] value,
	input  logic [LR_W-1:0]         lr,
	input  logic [KEEP_W-1:0]       keep,
	input  logic [SAL_W-1:0]        sal_all [CHANNELS],
	output logic [SAL_W-1:0]        sal,
	output logic signed [VAL_W-1:0] gated
);

	logic [SAL_W-1:0]        sal_q;
	logic signed [VAL_W-1:0] val_s1;
	logic [PROD_W-1:0]       prod_s1;

	logic [VAL_W-2:0]        rpos;
	logic [VAL_W-1:0]        mag;
	logic [VAL_W:0]          neg_val;
	logic [TGT_W-1:0]        target;
	logic signed [TGT_W:0]   diff;
	logic signed [TGT_W+LR_W+1:0] step;
	logic signed [TGT_W+2:0] sum;
	logic [SAL_W-1:0]        sal_next;
	logic [KEEP_W-1:0]       rank;

	// positive part of reward and magnitude of percept
	always_comb begin
		rpos    = reward[VAL_W-1] ? '0 : reward[VAL_W-2:0];
		neg_val = 17'd0 - {value[VAL_W-1], value};
		mag     = value[VAL_W-1] ? neg_val[VAL_W-1:0] : value;
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			val_s1  <= value;
			prod_s1 <= PROD_W'(rpos) * PROD_W'(mag);
		end
	end

	// second stage of the update: move toward target at the learning rate, then clamp
	always_comb begin
		target = TGT_W'(SAL_ONE) + TGT_W'(prod_s1[PROD_W-1:11]);
		diff   = $signed({1'b0, target}) - $signed({5'b0, sal_q});
		step   = $signed({1'b0, lr}) * diff;
		sum    = $signed({7'b0, sal_q}) + step[TGT_W+LR_W+1:16];
		if (sum < $signed({7'b0, SAL_MIN}))
			sal_next = SAL_MIN;
		else if (sum > $signed({7'b0, SAL_MAX}))
			sal_next = SAL_MAX;
		else
			sal_next = sum[SAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sal_q <= SAL_ONE;
		end else if (ctrl.commit) begin
			sal_q <= sal_next;
		end
	end

	// lanes ahead of this one: higher salience, or equal with lower index
	always_comb begin
		rank = '0;
		for (int j = 0; j < CHANNELS; j++) begin
			if (sal_all[j] > sal_q || (sal_all[j] == sal_q && j < LANE))
				rank = rank + KEEP_W'(1);
		end
		gated = (rank >= keep) ? (val_s1 >>> 2) : val_s1;
	end

	assign sal = sal_q;

endmodule

>>> hw/rtl/stgl_merge.sv
// merge stage: collects the lane results into the registered result transaction
// depends on stgl_pkg and stgl_result_if
module stgl_merge
	import stgl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic signed [VAL_W-1:0] gated [CHANNELS],
	input  logic [CNT_W-1:0]        attend_total,
	input  logic [CNT_W-1:0]        update_total,
	output logic                    free,
	stgl_result_if.source           results
);

	logic                    valid_q;
	logic signed [VAL_W-1:0] gated_q [MAX_CH];
	logic signed [VAL_W-1:0] gated_pad [MAX_CH];
	logic [CNT_W-1:0]        attend_q;
	logic [CNT_W-1:0]        update_q;

	// channels beyond the configured count read zero
	for (genvar i = 0; i < MAX_CH; i++) begin : g_pad
		if (i < CHANNELS) begin : g_live
			assign gated_pad[i] = gated[i];
		end else begin : g_zero
			assign gated_pad[i] = '0;
		end
	end

	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gated_q  <= gated_pad;
			attend_q <= attend_total;
			update_q <= update_total;
		end
	end

	assign results.valid        = valid_q;
	assign results.gated_0      = gated_q[0];
	assign results.gated_1      = gated_q[1];
	assign results.gated_2      = gated_q[2];
	assign results.gated_3      = gated_q[3];
	assign results.gated_4      = gated_q[4];
	assign results.gated_5      = gated_q[5];
	assign results.gated_6      = gated_q[6];
	assign results.gated_7      = gated_q[7];
	assign results.attend_total = attend_q;
	assign results.update_total = update_q;

endmodule

>>> hw/rtl/salience_topk_gate_learner.sv
// salience top-k gate learner: one item at a time
// attend: accepted, then ranked and loaded into the result register once that register is free
// update: accepted with the reward times percept product taken into each lane,
// salience written on the next cycle; the two lane multiplies are split between capture and commit
// a finished result waits in the result register while the next item is taken
// async active-low reset: saliences 1.0, counters zero, keep 1, learning rate 6554
module salience_topk_gate_learner
	import stgl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	stgl_item_if.sink             items,
	stgl_result_if.source         results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t            state_q;
	state_t            state_next;
	lane_ctrl_t        ctrl;
	logic              load;
	logic              free;
	logic              accept;

	logic [KEEP_W-1:0] keep_q;
	logic [LR_W-1:0]   lr_q;
	logic [KEEP_W-1:0] keep_eff;
	logic [LR_W-1:0]   lr_eff;
	logic [CNT_W-1:0]  attend_cnt_q;
	logic [CNT_W-1:0]  update_cnt_q;

	logic signed [VAL_W-1:0] value_v [MAX_CH];
	logic signed [VAL_W-1:0] gated_v [CHANNELS];
	logic [SAL_W-1:0]        sal_all [CHANNELS];

	assign value_v[0] = items.value_0;
	assign value_v[1] = items.value_1;
	assign value_v[2] = items.value_2;
	assign value_v[3] = items.value_3;
	assign value_v[4] = items.value_4;
	assign value_v[5] = items.value_5;
	assign value_v[6] = items.value_6;
	assign value_v[7] = items.value_7;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
			lr_q   <= LR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEEP_COUNT:    keep_q <= cfg_data[KEEP_W-1:0];
				REG_LEARNING_RATE: lr_q   <= cfg_data[LR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (keep_q == '0)
			keep_eff = KEEP_W'(1);
		else if (keep_q > KEEP_W'(CHANNELS))
			keep_eff = KEEP_W'(CHANNELS);
		else
			keep_eff = keep_q;
		lr_eff = (lr_q > LR_MAX) ? LR_MAX : lr_q;
	end

	assign accept = items.valid && items.ready;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_next = items.command ? ST_UPDATE : ST_ATTEND;
			end
			ST_UPDATE: state_next = ST_IDLE;
			ST_ATTEND: begin
				if (free)
					state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		items.ready  = 1'b0;
		ctrl.capture = 1'b0;
		ctrl.commit  = 1'b0;
		load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				items.ready  = 1'b1;
				ctrl.capture = items.valid;
			end
			ST_UPDATE: ctrl.commit = 1'b1;
			ST_ATTEND: load = free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			attend_cnt_q <= '0;
			update_cnt_q <= '0;
		end else begin
			state_q <= state_next;
			if (load)
				attend_cnt_q <= attend_cnt_q + CNT_W'(1);
			if (ctrl.commit)
				update_cnt_q <= update_cnt_q + CNT_W'(1);
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		stgl_lane #(
			.CHANNELS (CHANNELS),
			.LANE     (c)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.reward  (items.reward),
			.value   (value_v[c]),
			.lr      (lr_eff),
			.keep    (keep_eff),
			.sal_all (sal_all),
			.sal     (sal_all[c]),
			.gated   (gated_v[c])
		);
	end

	stgl_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.gated        (gated_v),
		.attend_total (attend_cnt_q + CNT_W'(1)),
		.update_total (update_cnt_q),
		.free         (free),
		.results      (results)
	);

endmodule

>>> hw/rtl/stgl_checker.sv
// port-level checker for the salience top-k gate learner, bound to the top level
// depends on stgl_pkg and the top level's port names
module stgl_checker
	import stgl_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             item_command,
	input logic             result_valid,
	input logic             result_ready,
	input logic [CNT_W-1:0] attend_total
);

	logic             seen_q;
	logic [CNT_W-1:0] last_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_total_q <= '0;
		end else if (result_valid && result_ready) begin
			seen_q       <= 1'b1;
			last_total_q <= attend_total;
		end
	end

	// a held result transaction keeps its count
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(attend_total))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous one busy");

	// a new result follows an accepted attend transaction
	a_from_attend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready && !item_command, 2))
		else $error("result without attend");

	// consecutive results count attends one apart
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && seen_q |-> attend_total == last_total_q + CNT_W'(1))
		else $error("attend count skipped");

endmodule

bind salience_topk_gate_learner stgl_checker u_stgl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (items.valid),
	.item_ready   (items.ready),
	.item_command (items.command),
	.result_valid (results.valid),
	.result_ready (results.ready),
	.attend_total (results.attend_total)
);

>>> sim/stgl_gate_checker.sv
// checker for the salience top-k gate learner: predicts gated vectors and counts
// from the item and register ports and checks them on the result port; depends on stgl_pkg
`timescale 1ns / 100ps

module stgl_gate_checker
	import stgl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	stgl_item_if                  items,
	stgl_result_if                results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    checked
);

	localparam longint ONE_Q13   = SAL_ONE;
	localparam longint FLOOR_Q13 = SAL_MIN;
	localparam longint CEIL_Q13  = SAL_MAX;
	localparam longint LR_CEIL   = LR_MAX;

	typedef struct packed {
		logic [MAX_CH-1:0][VAL_W-1:0] gated;
		logic [CNT_W-1:0]             attends;
		logic [CNT_W-1:0]             updates;
	} gate_result_t;

	gate_result_t     expected_gates[$];
	logic [SAL_W-1:0] sal_q13 [MAX_CH];
	logic [CNT_W-1:0] attend_cnt;
	logic [CNT_W-1:0] update_cnt;
	logic [KEEP_W-1:0] keep;
	logic [LR_W-1:0]  rate;

	function automatic gate_result_t gate_vector(logic [MAX_CH-1:0][VAL_W-1:0] vec);
		gate_result_t r;
		int kept;
		int rank;
		logic signed [VAL_W-1:0] v;
		kept = keep;
		if (kept > MAX_CH) kept = MAX_CH;
		if (kept < 1) kept = 1;
		for (int i = 0; i < MAX_CH; i++) begin
			rank = 0;
			for (int j = 0; j < MAX_CH; j++) begin
				if (sal_q13[j] > sal_q13[i] || (sal_q13[j] == sal_q13[i] && j < i)) rank++;
			end
			v = vec[i];
			if (rank >= kept) v = v >>> 2;
			r.gated[i] = v;
		end
		attend_cnt = attend_cnt + 1;
		r.attends = attend_cnt;
		r.updates = update_cnt;
		return r;
	endfunction

	function automatic void adapt_saliences(logic signed [VAL_W-1:0] reward,
		logic [MAX_CH-1:0][VAL_W-1:0] vec);
		longint gain;
		longint mag;
		longint tgt;
		longint s;
		longint lr_eff;
		logic signed [VAL_W-1:0] pv;
		gain = reward;
		if (gain < 0) gain = 0;
		lr_eff = rate;
		if (lr_eff > LR_CEIL) lr_eff = LR_CEIL;
		for (int i = 0; i < MAX_CH; i++) begin
			pv = vec[i];
			mag = pv;
			if (mag < 0) mag = -mag;
			tgt = ONE_Q13 + ((gain * mag) >>> 11);
			s = sal_q13[i];
			s = s + ((lr_eff * (tgt - s)) >>> 16);
			if (s < FLOOR_Q13) s = FLOOR_Q13;
			if (s > CEIL_Q13) s = CEIL_Q13;
			sal_q13[i] = s[SAL_W-1:0];
		end
		update_cnt = update_cnt + 1;
	endfunction

	task automatic flag(string what, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] got_v);
		if (mismatches < 10) $display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		gate_result_t want;
		gate_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_CH; i++) sal_q13[i] = SAL_ONE;
			attend_cnt = '0;
			update_cnt = '0;
			keep = KEEP_RESET;
			rate = LR_RESET;
			expected_gates.delete();
			mismatches = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (results.valid && results.ready) begin
				got.gated = {results.gated_7, results.gated_6, results.gated_5, results.gated_4,
					results.gated_3, results.gated_2, results.gated_1, results.gated_0};
				got.attends = results.attend_total;
				got.updates = results.update_total;
				if (expected_gates.size() == 0) begin
					if (mismatches < 10)
						$display("result transaction with nothing pending, attend_total %0d",
							got.attends);
					mismatches++;
				end else begin
					want = expected_gates.pop_front();
					checked++;
					for (int i = 0; i < MAX_CH; i++)
						if (want.gated[i] !== got.gated[i])
							flag($sformatf("gated_%0d (result %0d)", i, checked),
								want.gated[i], got.gated[i]);
					if (want.attends !== got.attends)
						flag($sformatf("attend_total (result %0d)", checked),
							want.attends, got.attends);
					if (want.updates !== got.updates)
						flag($sformatf("update_total (result %0d)", checked),
							want.updates, got.updates);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_KEEP_COUNT) keep = cfg_data[KEEP_W-1:0];
				else if (cfg_index == REG_LEARNING_RATE) rate = cfg_data[LR_W-1:0];
			end
			if (items.valid && items.ready) begin
				if (!items.command)
					expected_gates.push_back(gate_vector({items.value_7, items.value_6,
						items.value_5, items.value_4, items.value_3, items.value_2,
						items.value_1, items.value_0}));
				else
					adapt_saliences(items.reward, {items.value_7, items.value_6,
						items.value_5, items.value_4, items.value_3, items.value_2,
						items.value_1, items.value_0});
			end
			pending = expected_gates.size();
		end
	end

endmodule

>>> sim/tb.sv
// testbench top for the salience top-k gate learner: clock, reset, stimulus and verdict
// drives directed then random attend/update transactions under several register settings;
// depends on stgl_pkg, the channel interfaces, the block and stgl_gate_checker
`timescale 1ns / 100ps

module tb;
	import stgl_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int checked;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int n_attend       = 0;
	int n_update       = 0;
	int n_settings     = 1;

	stgl_item_if   item_ch();
	stgl_result_if result_ch();

	salience_topk_gate_learner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	stgl_gate_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (item_ch),
		.results    (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [VAL_W-1:0] rand_channel();
		int k;
		k = $urandom_range(9);
		if (k < 3) return VAL_W'($urandom);
		if (k < 8) return VAL_W'($urandom_range(12000)) - VAL_W'(6000);
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] rand_reward();
		int k;
		k = $urandom_range(9);
		if (k < 3) return 16'h8000 | VAL_W'($urandom_range(32767));
		if (k < 8) return VAL_W'($urandom_range(6000));
		return VAL_W'($urandom);
	endfunction

	task automatic send_item(bit cmd, logic [VAL_W-1:0] rwd, logic [MAX_CH-1:0][VAL_W-1:0] vec);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.command <= cmd;
		item_ch.reward  <= rwd;
		item_ch.value_0 <= vec[0];
		item_ch.value_1 <= vec[1];
		item_ch.value_2 <= vec[2];
		item_ch.value_3 <= vec[3];
		item_ch.value_4 <= vec[4];
		item_ch.value_5 <= vec[5];
		item_ch.value_6 <= vec[6];
		item_ch.value_7 <= vec[7];
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		if (cmd) n_update++;
		else n_attend++;
	endtask

	task automatic send_random();
		logic [MAX_CH-1:0][VAL_W-1:0] vec;
		for (int i = 0; i < MAX_CH; i++) vec[i] = rand_channel();
		send_item($urandom_range(99) >= 45, rand_reward(), vec);
	endtask

	// hold off the sender until every gated result is back and the block has settled
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int idle_tab[4]  = '{0, 79, 0, 25};
		int stall_tab[4] = '{0, 0, 79, 25};
		int keep_tab[8]  = '{0, 8, 3, 15, 5, 2, -1, -1};
		int lr_tab[8]    = '{65536, 0, 131071, 1, 6554, -1, -1, 32768};
		int keep_val;
		int lr_val;
		int waited;
		logic [MAX_CH-1:0][VAL_W-1:0] vec;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_KEEP_COUNT;
		cfg_data        = '0;
		item_ch.valid   = 1'b0;
		item_ch.command = 1'b0;
		item_ch.reward  = '0;
		item_ch.value_0 = '0;
		item_ch.value_1 = '0;
		item_ch.value_2 = '0;
		item_ch.value_3 = '0;
		item_ch.value_4 = '0;
		item_ch.value_5 = '0;
		item_ch.value_6 = '0;
		item_ch.value_7 = '0;
		result_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: keep one, equal saliences so ties go to channel 0
		send_item(1'b0, 16'h0000, {8{16'h7FFF}});
		send_item(1'b0, 16'h0000, {8{16'h8000}});
		send_item(1'b0, 16'h0000, {16'hFFFF, 16'h0001, 16'hFFFE, 16'h0002,
			16'hFFFD, 16'h0003, 16'hFFFC, 16'h0005});
		// non-positive reward: target stays at one
		for (int i = 0; i < MAX_CH; i++) vec[i] = rand_channel();
		send_item(1'b1, 16'h8000, vec);
		send_item(1'b1, 16'h0000, {8{16'h8000}});
		send_random();
		// single channel rises
		send_item(1'b1, 16'h1000, {16'h0, 16'h0, 16'h0, 16'h0, 16'h1000, 16'h0, 16'h0, 16'h0});
		send_item(1'b0, 16'h0000, {8{16'h4000}});
		// full reward with the largest percept magnitude hits the upper clamp
		send_item(1'b1, 16'h7FFF, {16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
		send_item(1'b0, 16'h0000, {8{16'hC000}});
		send_item(1'b1, 16'h7FFF, {8{16'h8000}});
		send_item(1'b0, 16'h0000, {16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000,
			16'h0004, 16'hFFFB, 16'h0007, 16'hFFF8});
		for (int i = 0; i < MAX_CH; i++) vec[i] = rand_channel();
		send_item(1'b1, 16'hF000, vec);
		send_item(1'b0, 16'h0000, {8{16'h0103}});
		for (int i = 0; i < MAX_CH; i++) vec[i] = rand_channel();
		send_item(1'b1, 16'h0800, vec);
		send_random();
		send_item(1'b0, 16'h0000, {8{16'hFFFF}});

		for (int seg = 0; seg < 8; seg++) begin
			send_idle_pct  = idle_tab[seg % 4];
			recv_stall_pct = stall_tab[seg % 4];
			keep_val = (keep_tab[seg] < 0) ? $urandom_range(15) : keep_tab[seg];
			lr_val   = (lr_tab[seg] < 0) ? $urandom_range(131071) : lr_tab[seg];
			// upper bits of the keep write are don't-care in the register
			write_reg(REG_KEEP_COUNT, (CFG_DATA_W'($urandom) & 17'h1FFF0) | CFG_DATA_W'(keep_val));
			write_reg(REG_LEARNING_RATE, CFG_DATA_W'(lr_val));
			n_settings++;
			repeat (140) begin
				if ($urandom_range(59) == 0) drain();
				send_random();
			end
		end

		item_ch.valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		$display("run covered %0d attend and %0d update transactions under %0d register settings",
			n_attend, n_update, n_settings);
		$display("%0d gated results checked, %0d mismatches, %0d left pending",
			checked, mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
